@@ design/pcfla_pkg.sv @@
// Package for the per-class free list allocator: sizes, codes and transfer types.
`default_nettype none
package pcfla_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int NUM_SLOTS   = 1024;
    localparam int WORD_BYTES  = 4;

    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int HEAD_W = SLOT_W + 1;
    localparam int FIX_W  = 17;
    localparam int ACC_W  = 21;
    localparam int PROD_W = HEAD_W + FIX_W;

    localparam logic [HEAD_W-1:0] NULL_CODE = HEAD_W'(NUM_SLOTS);

    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_INIT  = 2'd3;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BUSY      = 3'd1;
    localparam logic [2:0] STS_INVALID   = 3'd2;
    localparam logic [2:0] STS_EMPTY     = 3'd3;
    localparam logic [2:0] STS_NOT_READY = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  class_id;
        logic [9:0]  free_slot;
        logic [9:0]  base_slot;
        logic [19:0] pool_bytes;
        logic [15:0] item_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] got_slot;
        logic       is_ready;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_MUL,
        ST_CHECK,
        ST_WALK
    } t_state;

endpackage
`default_nettype wire

@@ design/pcfla_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pcfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ design/per_class_free_list_allocator_top.sv @@
// Per-class free list allocator: LIFO slot lists per class over one shared link memory.
//
// One request is taken when start is high and busy is low; its result shows on
// o_rsp for one cycle with o_done and cannot be held off. A ready query, a free
// and any request rejected on its fields at acceptance give their result the
// cycle after start, with busy staying low, so one such request may follow every
// cycle. An allocate that pops a slot first reads the head's link through the
// registered read of the link memory, then pops it in ST_ALLOC. An initialize
// whose pool would run past the last slot is rejected after the range compare.
// An initialize that carves n slots goes through the size multiply, the range
// compare, then one link memory write per slot. The link memory needs no clearing
// after reset; only written entries are ever read.
`default_nettype none
module per_class_free_list_allocator_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pcfla_pkg::t_req i_req,
    output logic               o_done,
    output pcfla_pkg::t_rsp    o_rsp
);

    localparam int CLS_W  = pcfla_pkg::CLS_W;
    localparam int SLOT_W = pcfla_pkg::SLOT_W;
    localparam int HEAD_W = pcfla_pkg::HEAD_W;
    localparam int FIX_W  = pcfla_pkg::FIX_W;
    localparam int ACC_W  = pcfla_pkg::ACC_W;
    localparam int PROD_W = pcfla_pkg::PROD_W;

    pcfla_pkg::t_state r_state, n_state;

    logic [HEAD_W-1:0] r_head  [pcfla_pkg::NUM_CLASSES];
    logic [HEAD_W-1:0] n_head  [pcfla_pkg::NUM_CLASSES];
    logic              r_ready [pcfla_pkg::NUM_CLASSES];
    logic              n_ready [pcfla_pkg::NUM_CLASSES];

    logic [CLS_W-1:0]  r_cls,   n_cls;
    logic [SLOT_W-1:0] r_base,  n_base;
    logic [19:0]       r_bytes, n_bytes;
    logic [FIX_W-1:0]  r_fixed, n_fixed;
    logic [PROD_W-1:0] r_prod,  n_prod;
    logic [ACC_W-1:0]  r_acc,   n_acc;
    logic [SLOT_W-1:0] r_slot,  n_slot;
    logic [HEAD_W-1:0] r_prev,  n_prev;
    logic              r_done,  n_done;
    pcfla_pkg::t_rsp   r_rsp,   n_rsp;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [HEAD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [HEAD_W-1:0] ram_rdata;

    logic [CLS_W-1:0]  in_cls;
    logic              in_range;
    logic [FIX_W-1:0]  in_fixed;
    logic [ACC_W-1:0]  acc_next;

    pcfla_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (pcfla_pkg::NUM_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != pcfla_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_rsp    = r_rsp;

    assign in_cls   = i_req.class_id[CLS_W-1:0];
    assign in_range = ({1'b0, i_req.class_id} < 4'(pcfla_pkg::NUM_CLASSES));
    // round the item size up to a whole word
    assign in_fixed = FIX_W'((FIX_W'(i_req.item_bytes) + FIX_W'(pcfla_pkg::WORD_BYTES - 1))
                      / pcfla_pkg::WORD_BYTES * pcfla_pkg::WORD_BYTES);
    assign acc_next = r_acc + ACC_W'(r_fixed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcfla_pkg::ST_IDLE;
            r_done  <= 1'b0;
            for (int i = 0; i < pcfla_pkg::NUM_CLASSES; i++) begin
                r_head[i]  <= pcfla_pkg::NULL_CODE;
                r_ready[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_head  <= n_head;
            r_ready <= n_ready;
        end
        r_cls   <= n_cls;
        r_base  <= n_base;
        r_bytes <= n_bytes;
        r_fixed <= n_fixed;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_slot  <= n_slot;
        r_prev  <= n_prev;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_ready   = r_ready;
        n_cls     = r_cls;
        n_base    = r_base;
        n_bytes   = r_bytes;
        n_fixed   = r_fixed;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_slot    = r_slot;
        n_prev    = r_prev;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = r_prev;
        ram_re    = 1'b0;
        ram_raddr = r_head[r_cls][SLOT_W-1:0];

        unique case (r_state)
            pcfla_pkg::ST_IDLE: begin
                if (start) begin
                    n_done         = 1'b1;
                    n_rsp.status   = pcfla_pkg::STS_OK;
                    n_rsp.got_slot = '0;
                    n_rsp.is_ready = in_range & r_ready[in_cls];
                    n_cls          = in_cls;
                    if (!in_range) begin
                        n_rsp.status = pcfla_pkg::STS_NOT_READY;
                    end else begin
                        unique case (i_req.req_type)
                            pcfla_pkg::REQ_QUERY: begin
                                n_rsp.status = pcfla_pkg::STS_OK;
                            end
                            pcfla_pkg::REQ_ALLOC: begin
                                if (!r_ready[in_cls]) begin
                                    n_rsp.status = pcfla_pkg::STS_NOT_READY;
                                end else if (r_head[in_cls] >= pcfla_pkg::NULL_CODE) begin
                                    n_rsp.status = pcfla_pkg::STS_EMPTY;
                                end else begin
                                    // fetch the link of the head, pop next cycle
                                    n_done    = 1'b0;
                                    ram_re    = 1'b1;
                                    ram_raddr = r_head[in_cls][SLOT_W-1:0];
                                    n_state   = pcfla_pkg::ST_ALLOC;
                                end
                            end
                            pcfla_pkg::REQ_FREE: begin
                                if (!r_ready[in_cls]) begin
                                    n_rsp.status = pcfla_pkg::STS_NOT_READY;
                                end else if ({1'b0, i_req.free_slot} >= pcfla_pkg::NULL_CODE) begin
                                    n_rsp.status = pcfla_pkg::STS_INVALID;
                                end else begin
                                    ram_we         = 1'b1;
                                    ram_waddr      = i_req.free_slot[SLOT_W-1:0];
                                    ram_wdata      = r_head[in_cls];
                                    n_head[in_cls] = HEAD_W'(i_req.free_slot);
                                end
                            end
                            pcfla_pkg::REQ_INIT: begin
                                if (r_ready[in_cls]) begin
                                    n_rsp.status = pcfla_pkg::STS_BUSY;
                                end else if (in_fixed == '0 ||
                                             FIX_W'(i_req.pool_bytes) < in_fixed &&
                                             i_req.pool_bytes[19:FIX_W] == '0) begin
                                    n_rsp.status = pcfla_pkg::STS_INVALID;
                                end else begin
                                    n_done  = 1'b0;
                                    n_fixed = in_fixed;
                                    n_base  = i_req.base_slot[SLOT_W-1:0];
                                    n_bytes = i_req.pool_bytes;
                                    n_state = pcfla_pkg::ST_MUL;
                                end
                            end
                            default: begin
                                n_rsp.status = pcfla_pkg::STS_OK;
                            end
                        endcase
                    end
                end
            end
            pcfla_pkg::ST_ALLOC: begin
                n_head[r_cls]  = ram_rdata;
                n_done         = 1'b1;
                n_rsp.status   = pcfla_pkg::STS_OK;
                n_rsp.got_slot = r_head[r_cls][SLOT_W-1:0];
                n_rsp.is_ready = 1'b1;
                n_state        = pcfla_pkg::ST_IDLE;
            end
            pcfla_pkg::ST_MUL: begin
                // pool too long when bytes >= (NUM_SLOTS - base + 1) * size
                n_prod  = PROD_W'(HEAD_W'(pcfla_pkg::NUM_SLOTS + 1) - HEAD_W'(r_base))
                          * PROD_W'(r_fixed);
                n_state = pcfla_pkg::ST_CHECK;
            end
            pcfla_pkg::ST_CHECK: begin
                if (r_prod <= PROD_W'(r_bytes)) begin
                    n_done         = 1'b1;
                    n_rsp.status   = pcfla_pkg::STS_INVALID;
                    n_rsp.got_slot = '0;
                    n_rsp.is_ready = 1'b0;
                    n_state        = pcfla_pkg::ST_IDLE;
                end else begin
                    n_acc   = ACC_W'(r_fixed);
                    n_slot  = r_base;
                    n_prev  = pcfla_pkg::NULL_CODE;
                    n_state = pcfla_pkg::ST_WALK;
                end
            end
            pcfla_pkg::ST_WALK: begin
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = r_prev;
                n_prev    = HEAD_W'(r_slot);
                n_slot    = r_slot + SLOT_W'(1);
                n_acc     = acc_next;
                // stop once another item no longer fits in the pool
                if (acc_next > ACC_W'(r_bytes)) begin
                    n_head[r_cls]  = HEAD_W'(r_slot);
                    n_ready[r_cls] = 1'b1;
                    n_done         = 1'b1;
                    n_rsp.status   = pcfla_pkg::STS_OK;
                    n_rsp.got_slot = '0;
                    n_rsp.is_ready = 1'b1;
                    n_state        = pcfla_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcfla_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/pcfla_chk.sv @@
// Port-level checker for the free list allocator, bound to the top level.
`default_nettype none
module pcfla_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire pcfla_pkg::t_req i_req,
    input wire logic            o_done,
    input wire pcfla_pkg::t_rsp o_rsp
);

    // a ready query completes in the next cycle
    a_query_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.req_type == pcfla_pkg::REQ_QUERY |=> o_done)
        else $error("ready query did not complete in one cycle");

    // only a successful transfer carries a slot
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status != pcfla_pkg::STS_OK |-> o_rsp.got_slot == '0)
        else $error("slot reported on a failed request");

    // rejection as already initialized implies the class is ready
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status == pcfla_pkg::STS_BUSY |-> o_rsp.is_ready)
        else $error("busy status on a class that is not ready");

    // no result while a request is still in work
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(busy) |-> !busy)
        else $error("result shown while still busy");

    // reset leaves the block idle and quiet
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("block not idle after reset");

endmodule

bind per_class_free_list_allocator_top pcfla_chk u_pcfla_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire
